// ===== rtl/assert_macros.svh =====
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RDU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdu assertion failed");

// next-cycle implication, checked outside reset
`define RDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdu assertion failed");

`endif

// ===== rtl/rdu_pkg.sv =====
// types, constants and helper functions for the range decomposer
package rdu_pkg;

    localparam int VAR_RANGE_COUNT_DEF = 8;

    localparam int ADDR_W  = 33;
    localparam int LOW_W   = 32;
    localparam int OUT_W   = 52;
    localparam int IDX_W   = 6;
    localparam int BITS_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BITS  = 2'd2;

    localparam logic [31:0]       FLASH_BASE_RST = 32'hFF00_0000;
    localparam logic [32:0]       FLASH_SIZE_RST = 33'h0_0100_0000;
    localparam logic [BITS_W-1:0] PHYS_BITS_RST  = 6'd48;
    localparam logic [BITS_W-1:0] PHYS_BITS_MIN  = 6'd36;
    localparam logic [BITS_W-1:0] PHYS_BITS_MAX  = 6'd52;

    localparam logic [LOW_W-1:0] ROUND_HI_MASK = 32'h0FFF_FFFF;
    localparam logic [LOW_W-1:0] ROUND_LO_MASK = 32'h03FF_FFFF;

    localparam logic [7:0] TYPE_UC = 8'd0;
    localparam logic [7:0] TYPE_WP = 8'd5;
    localparam logic [7:0] TYPE_WB = 8'd6;

    localparam logic [OUT_W-1:0] RANGE_ENABLE = 52'h800;
    localparam logic [OUT_W-1:0] PAGE_MASK    = 52'hFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FLASH,
        ST_WB,
        ST_UC
    } t_state;

    function automatic logic [OUT_W-1:0] range_mask_of(
        input logic [ADDR_W-1:0] size,
        input logic [OUT_W-1:0]  valid
    );
        logic [OUT_W-1:0] inv;
        inv = ~({{(OUT_W-ADDR_W){1'b0}}, size} - {{(OUT_W-1){1'b0}}, 1'b1});
        return (inv & valid) | RANGE_ENABLE;
    endfunction

    function automatic logic [OUT_W-1:0] range_base_of(
        input logic [ADDR_W-1:0] addr,
        input logic [OUT_W-1:0]  addr_valid,
        input logic [7:0]        mem_type
    );
        return ({{(OUT_W-ADDR_W){1'b0}}, addr} & addr_valid)
            | {{(OUT_W-8){1'b0}}, mem_type};
    endfunction

endpackage

// ===== rtl/rdu_msb_unit.sv =====
// shared highest-set-bit isolator used for the write-back and uncacheable range steps
module rdu_msb_unit
    import rdu_pkg::*;
(
    input  logic [ADDR_W-1:0] i_value,
    output logic [ADDR_W-1:0] o_msb
);

    logic [ADDR_W-1:0] rev;
    logic [ADDR_W-1:0] iso;

    always_comb begin
        for (int i = 0; i < ADDR_W; i++) begin
            rev[i] = i_value[ADDR_W-1-i];
        end
    end

    // lowest set bit of the reversed word
    assign iso = rev & (~rev + {{(ADDR_W-1){1'b0}}, 1'b1});

    always_comb begin
        for (int i = 0; i < ADDR_W; i++) begin
            o_msb[i] = iso[ADDR_W-1-i];
        end
    end

endmodule

// ===== rtl/mtrr_range_decomposer_unit.sv =====
// top level: sequencer and datapath of the variable-range decomposer
// an input passes ST_ROUND and ST_FLASH before its first entry is in the output register,
// then one entry a cycle while the output is not stalled; at most 33 entries per input
// the rate is set by the single shared highest-bit unit, used once per write-back or uncacheable entry
// input is not taken until the previous input's last entry is in the output register
// reset (synchronous, active low) clears the sequencer and restores register defaults
module mtrr_range_decomposer_unit
    import rdu_pkg::*;
#(
    parameter int VAR_RANGE_COUNT = VAR_RANGE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [LOW_W-1:0]      i_low_length,
    input  logic                  i_high_present,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IDX_W-1:0]      o_entry_index,
    output logic [OUT_W-1:0]      o_range_base,
    output logic [OUT_W-1:0]      o_range_mask,
    output logic                  o_beyond_limit,
    output logic                  o_last_entry
);

    t_state r_state, n_state;

    logic [31:0]       r_flash_base;
    logic [32:0]       r_flash_size;
    logic [BITS_W-1:0] r_phys_bits;

    logic [LOW_W-1:0]  r_low;
    logic              r_high;
    logic [ADDR_W-1:0] r_top, r_rem, r_off, r_cur, r_diff;
    logic [IDX_W-1:0]  r_k;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [OUT_W-1:0]  r_base, r_mask;
    logic              r_beyond, r_last;

    logic [BITS_W-1:0] bits_sat;
    logic [OUT_W-1:0]  valid_bits, addr_valid;
    logic [ADDR_W-1:0] n_top;
    logic [ADDR_W-1:0] msb_in, part, uc_base;
    logic              slot_free, emit, wb_done, uc_done, in_accept;
    logic [OUT_W-1:0]  e_base, e_mask;
    logic              e_last;

    // address width limits and valid bit masks
    always_comb begin
        if (r_phys_bits < PHYS_BITS_MIN) begin
            bits_sat = PHYS_BITS_MIN;
        end else if (r_phys_bits > PHYS_BITS_MAX) begin
            bits_sat = PHYS_BITS_MAX;
        end else begin
            bits_sat = r_phys_bits;
        end
        for (int i = 0; i < OUT_W; i++) begin
            valid_bits[i] = (BITS_W'(i) < bits_sat);
        end
    end

    assign addr_valid = valid_bits & ~PAGE_MASK;

    // rounding of the low length
    always_comb begin
        n_top = {1'b0, r_low};
        if (r_high) begin
            if ((r_low & ROUND_HI_MASK) != '0) begin
                n_top = {1'b0, r_low | ROUND_HI_MASK} + 33'd1;
            end
        end else begin
            if ((r_low & ROUND_LO_MASK) != '0) begin
                n_top = {1'b0, r_low | ROUND_LO_MASK} + 33'd1;
            end
        end
    end

    assign msb_in = (r_state == ST_UC) ? r_diff : r_rem;

    rdu_msb_unit u_msb (
        .i_value (msb_in),
        .o_msb   (part)
    );

    assign wb_done = (r_rem == part);
    assign uc_done = (r_diff == part);
    assign uc_base = r_cur - part;

    assign slot_free = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;

    // control outputs and entry fields
    always_comb begin
        o_in_ready = 1'b0;
        emit       = 1'b0;
        e_base     = '0;
        e_mask     = '0;
        e_last     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_ROUND: begin
            end
            ST_FLASH: begin
                emit   = slot_free;
                e_base = range_base_of({1'b0, r_flash_base}, addr_valid, TYPE_WP);
                e_mask = range_mask_of(r_flash_size, valid_bits);
                e_last = (r_top == '0);
            end
            ST_WB: begin
                emit   = slot_free;
                e_base = range_base_of(r_off, addr_valid, TYPE_WB);
                e_mask = range_mask_of(part, valid_bits);
                e_last = wb_done && (r_diff == '0);
            end
            ST_UC: begin
                emit   = slot_free;
                e_base = range_base_of(uc_base, addr_valid, TYPE_UC);
                e_mask = range_mask_of(part, valid_bits);
                e_last = uc_done;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_FLASH;
            end
            ST_FLASH: begin
                if (emit) begin
                    n_state = (r_top == '0) ? ST_IDLE : ST_WB;
                end
            end
            ST_WB: begin
                if (emit && wb_done) begin
                    n_state = (r_diff != '0) ? ST_UC : ST_IDLE;
                end
            end
            ST_UC: begin
                if (emit && uc_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_flash_base <= FLASH_BASE_RST;
            r_flash_size <= FLASH_SIZE_RST;
            r_phys_bits  <= PHYS_BITS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FLASH_BASE: r_flash_base <= i_cfg_wdata[31:0];
                    CFG_FLASH_SIZE: r_flash_size <= i_cfg_wdata[32:0];
                    CFG_PHYS_BITS:  r_phys_bits  <= i_cfg_wdata[BITS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_low  <= i_low_length;
            r_high <= i_high_present;
            r_k    <= '0;
        end
        if (r_state == ST_ROUND) begin
            r_top <= n_top;
        end
        if (r_state == ST_FLASH) begin
            r_diff <= r_top - {1'b0, r_low};
            r_rem  <= r_top;
            r_cur  <= r_top;
            r_off  <= '0;
        end
        if (emit) begin
            r_k      <= r_k + 6'd1;
            r_idx    <= r_k;
            r_base   <= e_base;
            r_mask   <= e_mask;
            r_beyond <= (r_k >= IDX_W'(VAR_RANGE_COUNT));
            r_last   <= e_last;
        end
        if (emit && (r_state == ST_WB)) begin
            r_off <= r_off | part;
            r_rem <= r_rem ^ part;
        end
        if (emit && (r_state == ST_UC)) begin
            r_cur  <= uc_base;
            r_diff <= r_diff ^ part;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_index  = r_idx;
    assign o_range_base   = r_base;
    assign o_range_mask   = r_mask;
    assign o_beyond_limit = r_beyond;
    assign o_last_entry   = r_last;

endmodule

// ===== rtl/rdu_checker.sv =====
// port-level checker for the range decomposer, bound to the top level
`include "assert_macros.svh"

module rdu_checker
    import rdu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [IDX_W-1:0]      o_entry_index,
    input logic [OUT_W-1:0]      o_range_base,
    input logic [OUT_W-1:0]      o_range_mask,
    input logic                  o_last_entry
);

    // a stalled result transaction stays valid and keeps its base, mask and index
    `RDU_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_range_base) && $stable(o_range_mask) && $stable(o_entry_index))

    // the block is busy right after taking an input
    `RDU_ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready)

    // a non-final entry on the output means more entries follow, so no new input yet
    `RDU_ASSERT_IMPL(a_busy_mid_list, o_out_valid && !o_last_entry, !o_in_ready)

    // the first entry is always the write-protected flash window
    `RDU_ASSERT_IMPL(a_first_is_wp, o_out_valid && (o_entry_index == '0), o_range_base[7:0] == TYPE_WP)

endmodule

bind mtrr_range_decomposer_unit rdu_checker u_rdu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_entry_index (o_entry_index),
    .o_range_base  (o_range_base),
    .o_range_mask  (o_range_mask),
    .o_last_entry  (o_last_entry)
);

// ===== dv/tb.sv =====
// testbench for mtrr_range_decomposer_unit: directed and random inputs checked against a range predictor
`timescale 1ns / 100ps

module tb;
    import rdu_pkg::*;

    localparam int RANGE_REGS = VAR_RANGE_COUNT_DEF;
    localparam int MAX_ENTRIES = 40;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [OUT_W-1:0] base;
        logic [OUT_W-1:0] mask;
        logic             beyond;
        logic             last;
    } t_range_entry;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [LOW_W-1:0]      i_low_length;
    logic                  i_high_present;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [IDX_W-1:0]      o_entry_index;
    logic [OUT_W-1:0]      o_range_base;
    logic [OUT_W-1:0]      o_range_mask;
    logic                  o_beyond_limit;
    logic                  o_last_entry;

    mtrr_range_decomposer_unit #(
        .VAR_RANGE_COUNT(RANGE_REGS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_low_length   (i_low_length),
        .i_high_present (i_high_present),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_entry_index  (o_entry_index),
        .o_range_base   (o_range_base),
        .o_range_mask   (o_range_mask),
        .o_beyond_limit (o_beyond_limit),
        .o_last_entry   (o_last_entry)
    );

    // shadow copy of the configuration registers
    logic [31:0]       flash_base_q;
    logic [32:0]       flash_size_q;
    logic [BITS_W-1:0] phys_bits_q;

    t_range_entry expected_ranges[$];
    int           error_count;
    bit           in_idle_on;
    bit           out_stall_on;
    int           out_stall_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] top_pow2(logic [63:0] v);
        for (int b = 63; b >= 0; b--) begin
            if (v[b]) return 64'd1 << b;
        end
        return 64'd0;
    endfunction

    // works out every base/mask pair one transaction produces
    function automatic void predict_ranges(logic [31:0] len, logic hi);
        t_range_entry ents[MAX_ENTRIES];
        logic [63:0]  bits, valid, addr_valid, len64, top, off, part, cur, base, mask;
        int           k;
        bits = {58'd0, phys_bits_q};
        if (bits < 64'(PHYS_BITS_MIN)) bits = 64'(PHYS_BITS_MIN);
        if (bits > 64'(PHYS_BITS_MAX)) bits = 64'(PHYS_BITS_MAX);
        valid = (64'd1 << bits) - 64'd1;
        addr_valid = valid & ~64'hFFF;
        len64 = {32'd0, len};
        top = len64;
        if (hi) begin
            if ((len & ROUND_HI_MASK) != 0)
                top = len64 + (64'h1000_0000 - {32'd0, len & ROUND_HI_MASK});
        end else begin
            if ((len & ROUND_LO_MASK) != 0)
                top = len64 + (64'h0400_0000 - {32'd0, len & ROUND_LO_MASK});
        end
        k = 0;
        base = ({32'd0, flash_base_q} & addr_valid) | {56'd0, TYPE_WP};
        mask = (~({31'd0, flash_size_q} - 64'd1) & valid) | {12'd0, RANGE_ENABLE};
        ents[k] = '{k[IDX_W-1:0], base[OUT_W-1:0], mask[OUT_W-1:0], k >= RANGE_REGS, 1'b0};
        k++;
        off = 64'd0;
        while (top > off && k < MAX_ENTRIES) begin
            part = top_pow2(top - off);
            base = (off & addr_valid) | {56'd0, TYPE_WB};
            mask = (~(part - 64'd1) & valid) | {12'd0, RANGE_ENABLE};
            ents[k] = '{k[IDX_W-1:0], base[OUT_W-1:0], mask[OUT_W-1:0], k >= RANGE_REGS, 1'b0};
            off += part;
            k++;
        end
        cur = top;
        while (cur > len64 && k < MAX_ENTRIES) begin
            part = top_pow2(cur - len64);
            base = ((cur - part) & addr_valid) | {56'd0, TYPE_UC};
            mask = (~(part - 64'd1) & valid) | {12'd0, RANGE_ENABLE};
            ents[k] = '{k[IDX_W-1:0], base[OUT_W-1:0], mask[OUT_W-1:0], k >= RANGE_REGS, 1'b0};
            cur -= part;
            k++;
        end
        ents[k-1].last = 1'b1;
        for (int i = 0; i < k; i++) expected_ranges.push_back(ents[i]);
    endfunction

    // starts and ends at a falling edge
    task automatic send_range(input logic [31:0] len, input logic hi);
        int   gap;
        logic taken;
        gap = in_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_low_length = len;
        i_high_present = hi;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
            if (taken) predict_ranges(len, hi);
            @(negedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        i_in_valid = 1'b0;
        while (expected_ranges.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_for_drain();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FLASH_BASE: flash_base_q = data[31:0];
            CFG_FLASH_SIZE: flash_size_q = data[32:0];
            CFG_PHYS_BITS:  phys_bits_q = data[BITS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] fb, input logic [32:0] fs,
                             input logic [BITS_W-1:0] pb);
        write_reg(CFG_FLASH_BASE, {1'b0, fb});
        write_reg(CFG_FLASH_SIZE, fs);
        write_reg(CFG_PHYS_BITS, {{(CFG_DATA_W-BITS_W){1'b0}}, pb});
    endtask

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom & 32'hFC00_0000;
            2: return $urandom & 32'hF000_0000;
            3: return ($urandom & 32'hFC00_0000) - $urandom_range(1, 4096);
            4: return $urandom_range(0, 32'h00FF_FFFF);
            5: return 32'hF000_0000 | $urandom;
            6: begin
                case ($urandom_range(0, 2))
                    0: return 32'd0;
                    1: return 32'hFFFF_FFFF;
                    default: return 32'h0010_0000;
                endcase
            end
            default: return ($urandom & 32'hF000_0000) + 32'd1;
        endcase
    endfunction

    task automatic write_random_config();
        logic [32:0] fs;
        case ($urandom_range(0, 3))
            0, 1: fs = 33'd1 << $urandom_range(12, 32);
            2: fs = {$urandom_range(0, 1) == 1, $urandom};
            default: fs = ($urandom_range(0, 1) == 1) ? 33'd0 : 33'h1_FFFF_FFFF;
        endcase
        write_all($urandom, fs, ($urandom_range(0, 3) == 0) ? BITS_W'($urandom_range(0, 63))
                                                           : BITS_W'($urandom_range(36, 52)));
    endtask

    always @(negedge i_clk) begin
        if (!out_stall_on) begin
            i_out_ready = 1'b1;
        end else if (out_stall_left > 0) begin
            i_out_ready = 1'b0;
            out_stall_left--;
        end else begin
            i_out_ready = 1'b1;
            out_stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_range_entry want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ranges.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual index %0d",
                         $time, o_entry_index);
                error_count++;
            end else begin
                want = expected_ranges.pop_front();
                check_field("entry_index", 64'(want.idx), 64'(o_entry_index));
                check_field("range_base", 64'(want.base), 64'(o_range_base));
                check_field("range_mask", 64'(want.mask), 64'(o_range_mask));
                check_field("beyond_limit", 64'(want.beyond), 64'(o_beyond_limit));
                check_field("last_entry", 64'(want.last), 64'(o_last_entry));
            end
        end
    end

    task automatic test_reset_defaults();
        in_idle_on = 1'b0;
        out_stall_on = 1'b0;
        send_range(32'd0, 1'b0);
        send_range(32'd0, 1'b1);
        send_range(32'h0010_0000, 1'b0);
        send_range(32'hFFFF_FFFF, 1'b0);
        send_range(32'hFFFF_FFFF, 1'b1);
        send_range(32'h1000_0000, 1'b1);
        send_range(32'h0400_0000, 1'b0);
    endtask

    task automatic test_length_extremes();
        in_idle_on = 1'b1;
        out_stall_on = 1'b1;
        send_range(32'h0FFF_FFFF, 1'b1);
        send_range(32'hF800_0001, 1'b0);
        send_range(32'hE000_0001, 1'b1);
        send_range(32'h0000_0001, 1'b1);
        send_range(32'h0000_1000, 1'b0);
        send_range(32'h8000_0000, 1'b0);
        send_range(32'h7FFF_FFFF, 1'b1);
        send_range(32'h5555_5555, 1'b0);
        send_range(32'hAAAA_AAAA, 1'b1);
        send_range(32'hBFFF_F000, 1'b0);
    endtask

    task automatic test_register_sweep();
        logic [31:0]       bases[3] = '{32'd0, 32'hFFFF_FFFF, 32'h1234_5ABC};
        logic [32:0]       sizes[5] = '{33'd0, 33'h1000, 33'h1_0000_0000,
                                        33'h1_FFFF_FFFF, 33'h3000};
        logic [BITS_W-1:0] widths[7] = '{6'd36, 6'd52, 6'd0, 6'd35, 6'd53, 6'd63, 6'd48};
        for (int i = 0; i < 7; i++) begin
            write_all(bases[i % 3], sizes[i % 5], widths[i]);
            send_range(rand_length(), 1'($urandom_range(0, 1)));
            send_range(32'hFFFF_FFFF, 1'(i % 2));
        end
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 300; n++) begin
            if (n % 60 == 0) write_random_config();
            if (n == 150) wait_for_drain();
            if (n % 50 == 0) begin
                in_idle_on = ($urandom_range(0, 3) != 0);
                out_stall_on = ($urandom_range(0, 3) != 0);
            end
            send_range(rand_length(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        error_count = 0;
        in_idle_on = 1'b0;
        out_stall_on = 1'b0;
        out_stall_left = 0;
        flash_base_q = FLASH_BASE_RST;
        flash_size_q = FLASH_SIZE_RST;
        phys_bits_q = PHYS_BITS_RST;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FLASH_BASE;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_low_length = '0;
        i_high_present = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_length_extremes();
        test_register_sweep();
        test_random_traffic();
        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rdu_pkg.sv
rtl/rdu_msb_unit.sv
rtl/mtrr_range_decomposer_unit.sv
rtl/rdu_checker.sv
dv/tb.sv
